// ----- sv/vrt_pkg.sv -----
// Package for the voxel ray traversal block: widths, request and result
// structs, status codes and box register indexes. No dependencies.
package vrt_pkg;

  localparam int CoordIntBits  = 12;
  localparam int CoordFracBits = 8;
  localparam int TFracBits     = 24;
  localparam int CoordBits     = CoordIntBits + CoordFracBits;
  localparam int BoxBits       = CoordIntBits + 1;
  localparam int TInfBit       = CoordIntBits + TFracBits;
  localparam int TBits         = TInfBit + 1;
  localparam int TDeltaBits    = TFracBits + 1;
  localparam int DiffBits      = CoordBits + 1;
  localparam int SqBits        = 2 * DiffBits;
  localparam int LenBits       = SqBits + 2;
  localparam int CfgIdxBits    = 3;

  typedef enum logic [1:0] {
    StatLoaded  = 2'd0,
    StatDegen   = 2'd1,
    StatVoxel   = 2'd2,
    StatNoRay   = 2'd3
  } status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgMinX = 3'd0, CfgMaxX = 3'd1, CfgMinY = 3'd2,
    CfgMaxY = 3'd3, CfgMinZ = 3'd4, CfgMaxZ = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                        req_type;
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] start_z;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
    logic signed [CoordBits-1:0] end_z;
  } req_t;

  typedef struct packed {
    logic [1:0]                     status;
    logic signed [CoordIntBits-1:0] voxel_x;
    logic signed [CoordIntBits-1:0] voxel_y;
    logic signed [CoordIntBits-1:0] voxel_z;
    logic                           in_box;
    logic                           last;
  } rsp_t;

endpackage

// ----- sv/voxel_ray_traversal.sv -----
// Top level of the voxel ray traversal block: sequencer, shared squarer and
// shared restoring divider. Depends on vrt_pkg.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | vrt_pkg::req_t
//  rsp     | out       | rsp_valid/stall   | vrt_pkg::rsp_t
//  cfg     | in        | cfg_we            | index 3b, data 13b
//
// An advance runs three squares through the one multiplier, then the compare
// and step, then the result register. A load squares the three length
// differences, then runs two divisions per moving axis (operand load, 37
// one-bit steps, store) and sets an infinite boundary for each axis without
// motion, then the result register. No clearing pass after reset. The request
// side is stalled from acceptance until the result is taken.
module voxel_ray_traversal (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                req_valid_i,
  output logic                                req_stall_o,
  input  vrt_pkg::req_t                       req_i,
  output logic                                rsp_valid_o,
  input  logic                                rsp_stall_i,
  output vrt_pkg::rsp_t                       rsp_o,
  input  logic                                cfg_we_i,
  input  logic [vrt_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [vrt_pkg::BoxBits-1:0]         cfg_data_i
);
  import vrt_pkg::*;

  localparam int DivBits = TBits;   // quotient width of the shared divider
  localparam int CntBits = $clog2(DivBits + 1);

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StLSq  = 7'b0000010,
    StLDiv = 7'b0000100,
    StASq  = 7'b0001000,
    StACmp = 7'b0010000,
    StStep = 7'b0100000,
    StOut  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Box registers.
  logic signed [BoxBits-1:0] box_q [6];

  // Ray state.
  logic                           active_q;
  logic signed [CoordIntBits-1:0] cur_q [3];
  logic signed [CoordIntBits-1:0] end_q [3];
  logic signed [1:0]              sgn_q [3];
  logic [TBits-1:0]               tnb_q [3];
  logic [TDeltaBits-1:0]          tpv_q [3];
  logic signed [CoordBits-1:0]    org_q [3];
  logic [LenBits-1:0]             len_q;
  logic [CoordFracBits-1:0]       frac_q [3];
  logic [CoordIntBits:0]          ad_q [3];

  // Sequencer working registers.
  logic [1:0]          axis_q;
  logic                pass_q;     // 0 tMax division, 1 tDelta division
  logic [LenBits-1:0]  acc_q;
  logic                moving_q;
  rsp_t                rsp_q;
  logic                rsp_valid_q;

  // Divider registers.
  logic [CntBits-1:0]            cnt_q;
  logic [DivBits-1:0]            quo_q;
  logic [DivBits+CoordBits:0]    rem_q;
  logic [CoordBits:0]            den_q;
  logic [DivBits-1:0]            num_q;

  logic accept;
  assign accept      = req_valid_i && !req_stall_o;
  assign req_stall_o = (state_q != StIdle) || rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Shared squarer: one signed difference per cycle.
  logic signed [DiffBits-1:0] sq_in;
  logic [DiffBits-1:0]        sq_abs;
  logic [SqBits-1:0]          sq_out;
  logic signed [CoordBits-1:0] req_s [3];
  logic signed [CoordBits-1:0] req_e [3];
  assign req_s[0] = req_i.start_x; assign req_s[1] = req_i.start_y;
  assign req_s[2] = req_i.start_z;
  assign req_e[0] = req_i.end_x;   assign req_e[1] = req_i.end_y;
  assign req_e[2] = req_i.end_z;

  // Latched request ends for the load squares.
  logic signed [CoordBits-1:0] lend_q [3];

  always_comb begin
    if (state_q == StLSq) begin
      sq_in = DiffBits'(lend_q[axis_q]) - DiffBits'(org_q[axis_q]);
    end else begin
      sq_in = DiffBits'($signed({cur_q[axis_q], {CoordFracBits{1'b0}}})) -
              DiffBits'(org_q[axis_q]);
    end
    sq_abs = sq_in[DiffBits-1] ? DiffBits'(-sq_in) : DiffBits'(sq_in);
    sq_out = sq_abs * sq_abs;
  end

  // Box test, end test and length test on the current voxel.
  logic in_box_w, at_end, last_w;
  always_comb begin
    in_box_w = 1'b1;
    at_end = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (BoxBits'(cur_q[a]) < box_q[2*a] || BoxBits'(cur_q[a]) >= box_q[2*a+1])
        in_box_w = 1'b0;
      if (cur_q[a] != end_q[a]) at_end = 1'b0;
    end
    last_w = at_end || (in_box_w && (acc_q > len_q));
  end

  // Axis choice: X if strictly least, else Y if strictly below Z, else Z.
  logic [1:0] pick;
  always_comb begin
    if (tnb_q[0] < tnb_q[1] && tnb_q[0] < tnb_q[2]) pick = 2'd0;
    else if (tnb_q[1] < tnb_q[2])                  pick = 2'd1;
    else                                           pick = 2'd2;
  end

  // Divider numerator for the tMax pass of the current axis.
  logic [CoordFracBits:0] bnum;
  always_comb begin
    if (sgn_q[axis_q] > 0) bnum = (CoordFracBits+1)'(1 << CoordFracBits) -
                                  (CoordFracBits+1)'(frac_q[axis_q]);
    else if (frac_q[axis_q] == '0) bnum = (CoordFracBits+1)'(1 << CoordFracBits);
    else bnum = (CoordFracBits+1)'(frac_q[axis_q]);
  end

  // Restoring divider step.
  logic [DivBits+CoordBits:0] rem_sh;
  logic                       rem_ge;
  assign rem_sh = {rem_q[DivBits+CoordBits-1:0], num_q[DivBits-1]};
  assign rem_ge = rem_sh >= (DivBits+CoordBits+1)'(den_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (accept) state_d = req_i.req_type ? StASq : StLSq;
      StLSq:  if (axis_q == 2'd2) state_d = StLDiv;
      StLDiv: if (axis_q == 2'd2 &&
                  (ad_q[2] == '0 || (pass_q && cnt_q == CntBits'(DivBits + 1))))
                state_d = StOut;
      StASq:  if (axis_q == 2'd2) state_d = StACmp;
      StACmp: state_d = StOut;
      StStep: state_d = StOut;
      StOut:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rsp_valid_q <= 1'b0;
      active_q    <= 1'b0;
      axis_q      <= '0;
      pass_q      <= 1'b0;
      acc_q       <= '0;
      moving_q    <= 1'b0;
      rsp_q       <= '0;
      cnt_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      den_q       <= '0;
      num_q       <= '0;
      for (int a = 0; a < 3; a++) begin
        box_q[2*a]   <= BoxBits'(-(1 << CoordIntBits));
        box_q[2*a+1] <= BoxBits'(1 << CoordIntBits);
        cur_q[a] <= '0; end_q[a] <= '0; sgn_q[a] <= '0;
        tnb_q[a] <= '0; tpv_q[a] <= '0; org_q[a] <= '0;
        lend_q[a] <= '0; frac_q[a] <= '0; ad_q[a] <= '0;
      end
      len_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i <= CfgMaxZ) box_q[cfg_idx_i] <= cfg_data_i;
      if (rsp_valid_q && !rsp_stall_i) rsp_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          axis_q <= '0;
          acc_q  <= '0;
          if (accept) begin
            rsp_q <= '0;
            if (!req_i.req_type) begin
              moving_q <= 1'b0;
              for (int a = 0; a < 3; a++) begin
                logic signed [CoordIntBits-1:0] sv, ev;
                logic signed [CoordIntBits:0]   d;
                sv = req_s[a][CoordBits-1:CoordFracBits];
                ev = req_e[a][CoordBits-1:CoordFracBits];
                d  = (CoordIntBits+1)'(ev) - (CoordIntBits+1)'(sv);
                cur_q[a]  <= sv;
                end_q[a]  <= ev;
                org_q[a]  <= req_s[a];
                lend_q[a] <= req_e[a];
                frac_q[a] <= req_s[a][CoordFracBits-1:0];
                sgn_q[a]  <= (d > 0) ? 2'sd1 : ((d < 0) ? -2'sd1 : 2'sd0);
                ad_q[a]   <= d[CoordIntBits] ? (CoordIntBits+1)'(-d)
                                             : (CoordIntBits+1)'(d);
              end
            end
          end
        end
        StLSq, StASq: begin
          acc_q  <= acc_q + LenBits'(sq_out);
          axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
          pass_q <= 1'b0;
          cnt_q  <= '0;
          if (state_q == StLSq && axis_q == 2'd2) len_q <= acc_q + LenBits'(sq_out);
        end
        StLDiv: begin
          if (ad_q[axis_q] == '0) begin
            // Axis without motion: infinite boundary, no increment.
            tnb_q[axis_q] <= TBits'(1) << TInfBit;
            tpv_q[axis_q] <= '0;
            axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
          end else if (cnt_q == '0) begin
            // Load divider operands.
            moving_q <= 1'b1;
            rem_q <= '0;
            quo_q <= '0;
            cnt_q <= CntBits'(1);
            if (!pass_q) begin
              num_q <= DivBits'(bnum) << TFracBits;
              den_q <= (CoordBits+1)'({ad_q[axis_q], {CoordFracBits{1'b0}}});
            end else begin
              num_q <= DivBits'(1) << TFracBits;
              den_q <= (CoordBits+1)'(ad_q[axis_q]);
            end
          end else if (cnt_q != CntBits'(DivBits + 1)) begin
            rem_q <= rem_ge ? rem_sh - (DivBits+CoordBits+1)'(den_q) : rem_sh;
            quo_q <= {quo_q[DivBits-2:0], rem_ge};
            num_q <= num_q << 1;
            cnt_q <= cnt_q + CntBits'(1);
          end else begin
            cnt_q <= '0;
            if (!pass_q) begin
              tnb_q[axis_q] <= quo_q;
              pass_q <= 1'b1;
            end else begin
              tpv_q[axis_q] <= TDeltaBits'(quo_q);
              pass_q <= 1'b0;
              axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
            end
          end
        end
        StACmp: begin
          if (!active_q) begin
            rsp_q.status <= StatNoRay;
          end else begin
            rsp_q.status  <= StatVoxel;
            rsp_q.voxel_x <= cur_q[0];
            rsp_q.voxel_y <= cur_q[1];
            rsp_q.voxel_z <= cur_q[2];
            rsp_q.in_box  <= in_box_w;
            rsp_q.last    <= last_w;
            if (last_w) begin
              active_q <= 1'b0;
            end else begin
              logic [TBits:0] tsum;
              tsum = (TBits+1)'(tnb_q[pick]) + (TBits+1)'(tpv_q[pick]);
              cur_q[pick] <= cur_q[pick] + CoordIntBits'(sgn_q[pick]);
              if (!tnb_q[pick][TInfBit])
                tnb_q[pick] <= (tsum >= (TBits+1)'(1) << TInfBit)
                               ? TBits'((TBits'(1) << TInfBit) - TBits'(1))
                               : TBits'(tsum);
            end
          end
        end
        StStep: ;
        StOut: begin
          rsp_valid_q <= 1'b1;
          if (rsp_q.status != StatVoxel && rsp_q.status != StatNoRay) begin
            rsp_q.status <= moving_q ? StatLoaded : StatDegen;
            active_q     <= moving_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Assertions.
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> req_stall_o) else $error("accepting while busy");
  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_out_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |=> rsp_valid_q) else $error("result not raised");
  a_last_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StACmp && active_q && last_w) |=> !active_q)
    else $error("ray still active after last");
endmodule

// ----- test/tb_voxel_ray_traversal.sv -----
// Self-checking testbench for voxel_ray_traversal: directed and random ray loads and
// advances, with random idling on both channels, checked against an in-bench predictor.
// Depends on vrt_pkg and voxel_ray_traversal.
module tb_voxel_ray_traversal;
  import vrt_pkg::*;

  localparam longint unsigned TInf = 64'd1 << TInfBit;
  localparam longint unsigned TFinMax = TInf - 1;
  localparam int CycleLimit = 2000000;
  localparam int ReqBits = $bits(req_t);

  // Traversal predictor and store of expected results.
  class ray_walk_scoreboard;
    bit              active;
    int              cur[3];
    int              endv[3];
    int              sgn[3];
    longint unsigned tnb[3];
    longint unsigned tpv[3];
    longint          org[3];
    longint          len_sq;
    int              bmin[3];
    int              bmax[3];
    rsp_t            pending_results[$];
    int              n_mismatch;

    function new();
      for (int a = 0; a < 3; a++) begin
        bmin[a] = -2048;
        bmax[a] = 2048;
      end
    endfunction

    function void set_box(cfg_idx_e idx, int v);
      if (idx[0]) bmax[idx >> 1] = v;
      else bmin[idx >> 1] = v;
    endfunction

    // Predicts the result of one accepted request and updates the ray state.
    function void note_request(req_t r);
      rsp_t                     e;
      logic signed [CoordBits-1:0] s[3];
      logic signed [CoordBits-1:0] en[3];
      logic signed [CoordIntBits-1:0] w;
      longint unsigned          ad, num, fr;
      longint                   diff, dist_sq;
      int                       d, ax;
      bit                       moving, in_bx, at_end, last;
      e = '0;
      s = '{r.start_x, r.start_y, r.start_z};
      en = '{r.end_x, r.end_y, r.end_z};
      if (r.req_type == 1'b0) begin
        moving = 0;
        len_sq = 0;
        for (int a = 0; a < 3; a++) begin
          cur[a] = int'($signed(s[a][CoordBits-1:CoordFracBits]));
          endv[a] = int'($signed(en[a][CoordBits-1:CoordFracBits]));
          d = endv[a] - cur[a];
          ad = (d < 0) ? -d : d;
          org[a] = longint'(s[a]);
          diff = longint'(en[a]) - org[a];
          len_sq += diff * diff;
          sgn[a] = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
          if (d == 0) begin
            tnb[a] = TInf;
            tpv[a] = 0;
          end else begin
            fr = s[a][CoordFracBits-1:0];
            num = (d > 0) ? (256 - fr) : ((fr == 0) ? 256 : fr);
            tnb[a] = (num << TFracBits) / (ad << CoordFracBits);
            tpv[a] = (64'd1 << TFracBits) / ad;
            moving = 1;
          end
        end
        active = moving;
        e.status = moving ? StatLoaded : StatDegen;
      end else if (!active) begin
        e.status = StatNoRay;
      end else begin
        in_bx = 1;
        at_end = 1;
        dist_sq = 0;
        for (int a = 0; a < 3; a++) begin
          if (cur[a] < bmin[a] || cur[a] >= bmax[a]) in_bx = 0;
          if (cur[a] != endv[a]) at_end = 0;
          diff = longint'(cur[a]) * 256 - org[a];
          dist_sq += diff * diff;
        end
        last = at_end || (in_bx && dist_sq > len_sq);
        e.status = StatVoxel;
        e.voxel_x = CoordIntBits'(cur[0]);
        e.voxel_y = CoordIntBits'(cur[1]);
        e.voxel_z = CoordIntBits'(cur[2]);
        e.in_box = in_bx;
        e.last = last;
        if (last) begin
          active = 0;
        end else begin
          if (tnb[0] < tnb[1] && tnb[0] < tnb[2]) ax = 0;
          else if (tnb[1] < tnb[2]) ax = 1;
          else ax = 2;
          w = CoordIntBits'(cur[ax] + sgn[ax]);
          cur[ax] = w;
          if (tnb[ax] < TInf) begin
            tnb[ax] += tpv[ax];
            if (tnb[ax] > TFinMax) tnb[ax] = TFinMax;
          end
        end
      end
      pending_results = {pending_results, e};
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(rsp_t got);
      rsp_t exp_r;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %h, expected none", got);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.status !== exp_r.status || got.voxel_x !== exp_r.voxel_x ||
          got.voxel_y !== exp_r.voxel_y || got.voxel_z !== exp_r.voxel_z ||
          got.in_box !== exp_r.in_box || got.last !== exp_r.last) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("mismatch: expected st=%0d v=(%0d,%0d,%0d) box=%b last=%b",
                   exp_r.status, exp_r.voxel_x, exp_r.voxel_y, exp_r.voxel_z,
                   exp_r.in_box, exp_r.last);
          $display("          got      st=%0d v=(%0d,%0d,%0d) box=%b last=%b",
                   got.status, got.voxel_x, got.voxel_y, got.voxel_z, got.in_box,
                   got.last);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  req_valid_i = 1'b0;
  logic                  req_stall_o;
  req_t                  req_i = '0;
  logic                  rsp_valid_o;
  logic                  rsp_stall_i = 1'b0;
  rsp_t                  rsp_o;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [BoxBits-1:0]    cfg_data_i = '0;

  ray_walk_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;
  int cycles = 0;
  int n_items = 0;

  voxel_ray_traversal dut (.*);

  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL voxel_ray_traversal");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      rsp_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      rsp_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) sb.check_result(rsp_o);
  end

  // Random filler for a whole request.
  function automatic req_t rand_req();
    return ReqBits'({$urandom, $urandom, $urandom, $urandom});
  endfunction

  // Offers one request, with random idle cycles first, and waits until it is taken.
  task automatic send_request(req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid_i <= 1'b0;
      req_i <= rand_req();
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (req_stall_o);
    sb.note_request(r);
    n_items++;
  endtask

  task automatic write_box(cfg_idx_e idx, int v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= BoxBits'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_box(idx, v);
  endtask

  // Waits until the block is idle, then sets the whole box.
  task automatic set_box_all(int x0, int x1, int y0, int y1, int z0, int z1);
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    write_box(CfgMinX, x0);
    write_box(CfgMaxX, x1);
    write_box(CfgMinY, y0);
    write_box(CfgMaxY, y1);
    write_box(CfgMinZ, z0);
    write_box(CfgMaxZ, z1);
  endtask

  function automatic req_t load_of(int sx, int sy, int sz, int ex, int ey, int ez);
    req_t r;
    r = rand_req();
    r.req_type = 1'b0;
    r.start_x = CoordBits'(sx);
    r.start_y = CoordBits'(sy);
    r.start_z = CoordBits'(sz);
    r.end_x = CoordBits'(ex);
    r.end_y = CoordBits'(ey);
    r.end_z = CoordBits'(ez);
    return r;
  endfunction

  task automatic send_advances(int n);
    req_t r;
    for (int i = 0; i < n; i++) begin
      r = rand_req();
      r.req_type = 1'b1;
      send_request(r);
    end
  endtask

  function automatic int rand_frac();
    case ($urandom_range(3))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // A load with random content followed by a walk along it.
  task automatic random_ray();
    int sv[3], ev[3], c[3], s[3], e[3];
    int nvox;
    req_t r;
    nvox = 1;
    for (int a = 0; a < 3; a++) begin
      c[a] = $urandom_range(24) - 12;
      sv[a] = c[a] + $urandom_range(6) - 3;
      ev[a] = ($urandom_range(4) == 0) ? sv[a] : sv[a] + $urandom_range(10) - 5;
      nvox += (ev[a] > sv[a]) ? ev[a] - sv[a] : sv[a] - ev[a];
      s[a] = sv[a] * 256 + rand_frac();
      e[a] = ev[a] * 256 + rand_frac();
    end
    if ($urandom_range(9) == 0) begin
      r = rand_req();
      r.req_type = 1'b0;
      nvox = $urandom_range(6, 2);
    end else begin
      r = load_of(s[0], s[1], s[2], e[0], e[1], e[2]);
    end
    send_request(r);
    if ($urandom_range(7) == 0) nvox = $urandom_range(nvox);
    else nvox += $urandom_range(2);
    send_advances(nvox);
  endtask

  task automatic random_phase(int tx, int rx, int n);
    int stop_at;
    tx_idle_pct = tx;
    rx_stall_pct = rx;
    stop_at = n_items + n;
    while (n_items < stop_at) random_ray();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: no ray, degenerate ray, extreme ends, axis ties, negative walk.
    set_box_all(-2048, 2048, -2048, 2048, -2048, 2048);
    send_advances(1);
    send_request(load_of(291, -291, 5, 300, -260, 100));
    send_advances(1);
    send_request(load_of(-524288, -524288, -524288, 524287, 524287, 524287));
    send_advances(3);
    send_request(load_of(524287, 524287, 524287, -524288, -524288, -524288));
    send_advances(2);
    send_request(load_of(5 * 256, 0, 0, 256 + 128, 0, 0));
    send_advances(5);
    send_request(load_of(0, 0, 0, 3 * 256, 3 * 256, 0));
    send_advances(8);

    set_box_all(-4, 4, -4, 4, -4, 4);
    random_phase(0, 0, 160);
    set_box_all(2048, 2048, -20, 20, -20, 20);
    random_phase(54, 0, 160);
    set_box_all(-$urandom_range(12), $urandom_range(12), -$urandom_range(12),
                $urandom_range(12), -$urandom_range(12), $urandom_range(12));
    hold_left = 400;
    random_phase(0, 54, 160);
    set_box_all(-2048, 5, -3, 2048, -6, 6);
    random_phase(15, 15, 160);

    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.n_mismatch == 0) $display("PASS voxel_ray_traversal");
    else $display("FAIL voxel_ray_traversal");
    $finish;
  end

endmodule

// ----- voxel_ray_traversal.f -----
sv/vrt_pkg.sv
sv/voxel_ray_traversal.sv
test/tb_voxel_ray_traversal.sv
